FILE: design/xymms_pkg.sv
// shared constants and lookup tables for the xy model site update
package xymms_pkg;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [15:0] BETA_RESET = 16'd410;

    // quarter-wave sine, q1.14
    function automatic logic [14:0] sine_q14(input logic [5:0] i);
        logic [14:0] v;
        case (i)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd804;
            6'd2:  v = 15'd1606;
            6'd3:  v = 15'd2404;
            6'd4:  v = 15'd3196;
            6'd5:  v = 15'd3981;
            6'd6:  v = 15'd4756;
            6'd7:  v = 15'd5520;
            6'd8:  v = 15'd6270;
            6'd9:  v = 15'd7005;
            6'd10: v = 15'd7723;
            6'd11: v = 15'd8423;
            6'd12: v = 15'd9102;
            6'd13: v = 15'd9760;
            6'd14: v = 15'd10394;
            6'd15: v = 15'd11003;
            6'd16: v = 15'd11585;
            6'd17: v = 15'd12140;
            6'd18: v = 15'd12665;
            6'd19: v = 15'd13160;
            6'd20: v = 15'd13623;
            6'd21: v = 15'd14053;
            6'd22: v = 15'd14449;
            6'd23: v = 15'd14811;
            6'd24: v = 15'd15137;
            6'd25: v = 15'd15426;
            6'd26: v = 15'd15679;
            6'd27: v = 15'd15893;
            6'd28: v = 15'd16069;
            6'd29: v = 15'd16207;
            6'd30: v = 15'd16305;
            6'd31: v = 15'd16364;
            6'd32: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // exp(-k) for integer k, q1.16
    function automatic logic [16:0] exp_whole(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd24109;
            4'd2:  v = 17'd8869;
            4'd3:  v = 17'd3263;
            4'd4:  v = 17'd1200;
            4'd5:  v = 17'd442;
            4'd6:  v = 17'd162;
            4'd7:  v = 17'd60;
            4'd8:  v = 17'd22;
            4'd9:  v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-j/16), q1.16
    function automatic logic [16:0] exp_part(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd61565;
            5'd2:  v = 17'd57835;
            5'd3:  v = 17'd54331;
            5'd4:  v = 17'd51039;
            5'd5:  v = 17'd47947;
            5'd6:  v = 17'd45042;
            5'd7:  v = 17'd42313;
            5'd8:  v = 17'd39750;
            5'd9:  v = 17'd37341;
            5'd10: v = 17'd35079;
            5'd11: v = 17'd32954;
            5'd12: v = 17'd30957;
            5'd13: v = 17'd29081;
            5'd14: v = 17'd27319;
            5'd15: v = 17'd25664;
            5'd16: v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/xymms_ram.sv
// generic single-port ram with registered read
module xymms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: design/xymms_mul.sv
// shared unsigned multiplier with registered product
module xymms_mul (
    input  logic                          i_clk,
    input  logic [xymms_pkg::MUL_A_W-1:0] i_a,
    input  logic [xymms_pkg::MUL_B_W-1:0] i_b,
    output logic [xymms_pkg::MUL_P_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= xymms_pkg::MUL_P_W'(i_a) * xymms_pkg::MUL_P_W'(i_b);
    end

endmodule

FILE: design/xy_model_metropolis_site_update.sv
// metropolis site update for a periodic 2d xy lattice, top level
// when deltaS < 0 the move is accepted and the exponential steps are skipped
// one word at a time: start is taken only while idle; pace set by the single-port lattice ram
//   (five reads, at most one write) and ten cosine passes through the one shared multiplier
// reset: synchronous; a clearing pass over all LATTICE_X*LATTICE_Y sites zeroes the lattice,
//   busy stays high meanwhile; results cannot be stalled by the receiver
module xy_model_metropolis_site_update #(
    parameter int LATTICE_X  = 64,
    parameter int LATTICE_Y  = 64,
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic [5:0]         i_site_x,
    input  logic [5:0]         i_site_y,
    input  logic [15:0]        i_proposal_random,
    input  logic [15:0]        i_accept_random,
    output logic               o_valid,
    output logic               o_accepted,
    output logic [15:0]        o_site_angle,
    output logic signed [27:0] o_magnet_sum
);

    localparam int VOL  = LATTICE_X * LATTICE_Y;
    localparam int AW   = $clog2(VOL);
    localparam int XW   = $clog2(LATTICE_X);
    localparam int YW   = $clog2(LATTICE_Y);
    localparam int AB   = ANGLE_BITS;
    localparam int SW   = (AB < 16) ? AB : 16;
    localparam int FRAC = AB - 7;
    localparam int SHL  = (AB >= 16) ? AB - 16 : 0;
    localparam int SHR  = (AB < 16) ? 16 - AB : 0;
    localparam int PW   = xymms_pkg::MUL_P_W;
    localparam logic [27:0]   MAG_INIT = 28'(VOL * 16384);
    localparam logic [AB-1:0] PH_HALF  = AB'(1) << (AB - 1);
    localparam logic [AB-1:0] PH_QTR   = AB'(1) << (AB - 2);
    localparam logic [AB-2:0] OFF_QTR  = (AB - 1)'(1) << (AB - 2);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_COS, S_DEC, S_EXP1, S_EXP2, S_EXP3, S_FIN
    } t_state;

    t_state                r_state;
    logic [3:0]            r_cnt;
    logic [AW-1:0]         r_clr;
    logic [15:0]           r_beta;
    logic [XW-1:0]         r_x;
    logic [YW-1:0]         r_y;
    logic [AB-1:0]         r_scaled;
    logic [15:0]           r_ar;
    logic [AB-1:0]         r_old;
    logic [AB-1:0]         r_nb [4];
    logic [14:0]           r_cb_base;
    logic                  r_cb_neg;
    logic [3:0]            r_acc_step;
    logic                  r_acc_vld;
    logic signed [18:0]    r_ds;
    logic signed [16:0]    r_dm;
    logic [3:0]            r_k;
    logic [3:0]            r_j;
    logic                  r_zero;
    logic                  r_acc;
    logic [27:0]           r_mag;
    logic                  r_valid;
    logic                  r_accepted;
    logic [15:0]           r_angle;
    logic [27:0]           r_msum;

    logic [XW-1:0]         x_mod [64];
    logic [YW-1:0]         y_mod [64];
    logic [XW-1:0]         xp;
    logic [XW-1:0]         xm;
    logic [YW-1:0]         yp;
    logic [YW-1:0]         ym;
    logic [AB-1:0]         prop;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [SW-1:0]         ram_wdata;
    logic [SW-1:0]         ram_rdata;
    logic [3:0]            step_off;
    logic [AB-1:0]         ph;
    logic [AB-1:0]         phq;
    logic [AB-2:0]         off;
    logic [5:0]            idx;
    logic [5:0]            idx1;
    logic [FRAC-1:0]       frac;
    logic [14:0]           cb_base;
    logic [14:0]           cb_diff;
    logic [xymms_pkg::MUL_A_W-1:0] mul_a;
    logic [xymms_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]         mul_p;
    logic [14:0]           cos_val;
    logic signed [15:0]    cos_u;
    logic signed [15:0]    cos_s;
    logic [16:0]           e_val;
    logic [33:0]           fac_sum;
    logic [27:0]           n_mag;

    function automatic logic [AW-1:0] site_addr(input logic [XW-1:0] xx,
                                                 input logic [YW-1:0] yy);
        return AW'(32'(yy) * 32'(LATTICE_X) + 32'(xx));
    endfunction

    genvar g;
    for (g = 0; g < 64; g++) begin : g_mod
        assign x_mod[g] = XW'(g % LATTICE_X);
        assign y_mod[g] = YW'(g % LATTICE_Y);
    end

    assign xp   = (r_x == XW'(LATTICE_X - 1)) ? '0 : r_x + XW'(1);
    assign xm   = (r_x == '0) ? XW'(LATTICE_X - 1) : r_x - XW'(1);
    assign yp   = (r_y == YW'(LATTICE_Y - 1)) ? '0 : r_y + YW'(1);
    assign ym   = (r_y == '0) ? YW'(LATTICE_Y - 1) : r_y - YW'(1);
    assign prop = r_old + PH_HALF - r_scaled;
    assign busy = (r_state != S_IDLE);

    // lattice port
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = site_addr(r_x, r_y);
        ram_wdata = prop[SW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_READ: begin
                case (r_cnt)
                    4'd1:    ram_addr = site_addr(xp, r_y);
                    4'd2:    ram_addr = site_addr(xm, r_y);
                    4'd3:    ram_addr = site_addr(r_x, yp);
                    4'd4:    ram_addr = site_addr(r_x, ym);
                    default: ram_addr = site_addr(r_x, r_y);
                endcase
            end
            S_FIN: begin
                ram_we = r_acc;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // cosine front end: phase select, quadrant fold, table lookup
    assign step_off = r_cnt - 4'd2;

    always_comb begin
        case (r_cnt)
            4'd0:    ph = prop;
            4'd1:    ph = r_old;
            default: ph = step_off[0] ? r_nb[step_off[2:1]] - prop
                                      : r_nb[step_off[2:1]] - r_old;
        endcase
    end

    assign phq     = ph + PH_QTR;
    assign off     = phq[AB-2] ? OFF_QTR - {1'b0, phq[AB-3:0]} : {1'b0, phq[AB-3:0]};
    assign idx     = off[AB-2:FRAC];
    assign frac    = off[FRAC-1:0];
    assign idx1    = (idx < 6'd32) ? idx + 6'd1 : 6'd32;
    assign cb_base = xymms_pkg::sine_q14(idx);
    assign cb_diff = xymms_pkg::sine_q14(idx1) - cb_base;

    // cosine back end after the multiplier
    assign cos_val = r_cb_base + 15'(mul_p >> FRAC);
    assign cos_u   = {1'b0, cos_val};
    assign cos_s   = r_cb_neg ? -cos_u : cos_u;

    // exponential pieces
    assign e_val   = xymms_pkg::exp_part({1'b0, r_j}) - mul_p[PW-1:22];
    assign fac_sum = 34'(mul_p) + 34'd32768;
    assign n_mag   = r_mag + (r_acc ? {{11{r_dm[16]}}, r_dm} : 28'd0);

    // multiplier operand select
    always_comb begin
        mul_a = xymms_pkg::MUL_A_W'(cb_diff);
        mul_b = xymms_pkg::MUL_B_W'(frac);
        unique case (r_state)
            S_DEC: begin
                mul_a = xymms_pkg::MUL_A_W'(r_beta);
                mul_b = xymms_pkg::MUL_B_W'(r_ds[17:0]);
            end
            S_EXP1: begin
                mul_a = xymms_pkg::exp_part({1'b0, mul_p[25:22]})
                      - xymms_pkg::exp_part(5'({1'b0, mul_p[25:22]}) + 5'd1);
                mul_b = mul_p[21:0];
            end
            S_EXP2: begin
                mul_a = xymms_pkg::exp_whole(r_k);
                mul_b = xymms_pkg::MUL_B_W'(e_val);
            end
            default: begin
                mul_a = xymms_pkg::MUL_A_W'(cb_diff);
                mul_b = xymms_pkg::MUL_B_W'(frac);
            end
        endcase
    end

    xymms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    xymms_ram #(
        .WIDTH (SW),
        .DEPTH (VOL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_clr     <= '0;
            r_beta    <= xymms_pkg::BETA_RESET;
            r_mag     <= MAG_INIT;
            r_valid   <= 1'b0;
            r_acc_vld <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            r_acc_vld <= 1'b0;
            if (i_cfg_we) begin
                r_beta <= i_cfg_wdata;
            end

            // accumulate cosine terms one stage behind the multiplier
            if (r_acc_vld) begin
                case (r_acc_step)
                    4'd0:    r_dm <= {cos_s[15], cos_s};
                    4'd1:    r_dm <= r_dm - {cos_s[15], cos_s};
                    default: r_ds <= r_acc_step[0] ? r_ds - {{3{cos_s[15]}}, cos_s}
                                                   : r_ds + {{3{cos_s[15]}}, cos_s};
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(VOL - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_x      <= x_mod[i_site_x];
                        r_y      <= y_mod[i_site_y];
                        r_scaled <= AB'(({{AB{1'b0}}, i_proposal_random} << SHL) >> SHR);
                        r_ar     <= i_accept_random;
                        r_ds     <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_cnt == 4'd1) begin
                        r_old <= AB'(ram_rdata);
                    end else if (r_cnt != 4'd0) begin
                        r_nb[2'(r_cnt - 4'd2)] <= AB'(ram_rdata);
                    end
                    if (r_cnt == 4'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_COS;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_COS: begin
                    if (r_cnt == 4'd10) begin
                        r_state <= S_DEC;
                    end else begin
                        r_cb_base  <= cb_base;
                        r_cb_neg   <= phq[AB-1];
                        r_acc_step <= r_cnt;
                        r_acc_vld  <= 1'b1;
                        r_cnt      <= r_cnt + 4'd1;
                    end
                end
                S_DEC: begin
                    if (r_ds[18]) begin
                        r_acc   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_EXP1;
                    end
                end
                S_EXP1: begin
                    r_zero  <= (mul_p[PW-1:26] >= (PW - 26)'(12));
                    r_k     <= mul_p[29:26];
                    r_j     <= mul_p[25:22];
                    r_state <= S_EXP2;
                end
                S_EXP2: begin
                    r_state <= S_EXP3;
                end
                S_EXP3: begin
                    r_acc   <= !r_zero && ({2'b00, r_ar} < fac_sum[33:16]);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_mag      <= n_mag;
                    r_msum     <= n_mag;
                    r_accepted <= r_acc;
                    r_angle    <= 16'(r_acc ? prop[SW-1:0] : r_old[SW-1:0]);
                    r_valid    <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_accepted   = r_accepted;
    assign o_site_angle = r_angle;
    assign o_magnet_sum = r_msum;

endmodule

FILE: design/xymms_chk.sv
// port-level checker for the site update, bound to the top level
module xymms_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_valid)
        else $error("not busy after reset");

    // result word only shows while idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    // taking a word makes the block busy and no result comes at once
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("word taken without going busy");

    // strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind xy_model_metropolis_site_update xymms_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
